FILE: design/csim_pkg.sv
// Shared types and constants for the cosine similarity engine.
`timescale 1ns / 1ps
package csim_pkg;

    localparam int ELEM_W  = 16;
    localparam int DOT_W   = 42;
    localparam int NORM_W  = 41;
    localparam int MPLR_W  = 42;
    localparam int PROD_W  = 114;
    localparam int RHS_SH  = 30;
    localparam int Q_W     = 15;
    localparam int T_W     = 15;
    localparam int TT_W    = 30;
    localparam logic [Q_W-1:0] Q_ONE = 15'd16384;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a_elem;
        logic signed [ELEM_W-1:0] b_elem;
        logic                     last_pair;
    } t_req;

    typedef struct packed {
        logic signed [15:0] cosine;
        logic               degenerate;
    } t_res;

    typedef enum logic [1:0] {
        OP_NAB = 2'd0,
        OP_DSQ = 2'd1,
        OP_TT  = 2'd2,
        OP_LHS = 2'd3
    } t_mul_op;

    typedef struct packed {
        logic    mul_load;
        t_mul_op op;
        logic    capture;
        logic    srch_init;
        logic    srch_update;
        logic    emit;
        logic    clear;
    } t_cmd;

    typedef struct packed {
        logic degen;
        logic mul_done;
        logic lo_lt_hi;
    } t_sts;

endpackage

FILE: design/csim_datapath.sv
// Accumulators, shared shift-add multiplier and rounding search for the cosine engine.
`timescale 1ns / 1ps
module csim_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc_en,
    input  csim_pkg::t_req i_req,
    input  csim_pkg::t_cmd i_cmd,
    output csim_pkg::t_sts o_sts,
    output csim_pkg::t_res o_res,
    output logic          o_done
);
    import csim_pkg::*;

    logic signed [DOT_W-1:0]  r_dot;
    logic [NORM_W-1:0]        r_na, r_nb;
    logic [PROD_W-1:0]        r_mcand, r_acc;
    logic [MPLR_W-1:0]        r_mplr;
    logic [2*NORM_W-1:0]      r_nab;
    logic [2*MPLR_W-1:0]      r_dsq;
    logic [TT_W-1:0]          r_tt;
    logic [Q_W-1:0]           r_lo, r_hi;
    t_res                     r_res;
    logic                     r_done;

    logic signed [2*ELEM_W-1:0] p, pa, pb;
    logic signed [DOT_W:0]      dot_ext;
    logic [NORM_W:0]            na_ext, nb_ext;
    logic signed [DOT_W-1:0]    n_dot;
    logic [NORM_W-1:0]          n_na, n_nb;
    logic [MPLR_W-1:0]          mag;
    logic [Q_W:0]               mid_sum;
    logic [Q_W-1:0]             mid;
    logic [T_W-1:0]             t;
    logic [PROD_W-1:0]          rhs;
    logic                       reaches;
    logic                       degen;

    always_comb begin
        p  = i_req.a_elem * i_req.b_elem;
        pa = i_req.a_elem * i_req.a_elem;
        pb = i_req.b_elem * i_req.b_elem;
        dot_ext = {r_dot[DOT_W-1], r_dot} + (DOT_W+1)'(p);
        na_ext  = {1'b0, r_na} + (NORM_W+1)'(pa[2*ELEM_W-2:0]);
        nb_ext  = {1'b0, r_nb} + (NORM_W+1)'(pb[2*ELEM_W-2:0]);
        if (dot_ext[DOT_W] != dot_ext[DOT_W-1]) begin
            n_dot = dot_ext[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
        end else begin
            n_dot = dot_ext[DOT_W-1:0];
        end
        n_na = na_ext[NORM_W] ? {NORM_W{1'b1}} : na_ext[NORM_W-1:0];
        n_nb = nb_ext[NORM_W] ? {NORM_W{1'b1}} : nb_ext[NORM_W-1:0];
        mag  = r_dot[DOT_W-1] ? MPLR_W'(-r_dot) : MPLR_W'(r_dot);
        mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + 1'b1;
        mid  = mid_sum[Q_W:1];
        t    = T_W'({mid, 1'b0} - 1'b1);
        rhs  = {r_dsq[PROD_W-RHS_SH-1:0], {RHS_SH{1'b0}}};
        // The probe passes when (2q-1)^2 * na * nb <= 2^30 * dot^2.
        reaches = (r_acc <= rhs);
        degen = (r_na == '0) || (r_nb == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= '0;
            r_na   <= '0;
            r_nb   <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
            if (i_cmd.clear) begin
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
            end else if (i_acc_en) begin
                r_dot <= n_dot;
                r_na  <= n_na;
                r_nb  <= n_nb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_acc <= '0;
            case (i_cmd.op)
                OP_NAB: begin
                    r_mcand <= PROD_W'(r_na);
                    r_mplr  <= MPLR_W'(r_nb);
                end
                OP_DSQ: begin
                    r_mcand <= PROD_W'(mag);
                    r_mplr  <= mag;
                end
                OP_TT: begin
                    r_mcand <= PROD_W'(t);
                    r_mplr  <= MPLR_W'(t);
                end
                default: begin
                    r_mcand <= PROD_W'(r_nab);
                    r_mplr  <= MPLR_W'(r_tt);
                end
            endcase
        end else if (r_mplr != '0) begin
            if (r_mplr[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= {r_mcand[PROD_W-2:0], 1'b0};
            r_mplr  <= {1'b0, r_mplr[MPLR_W-1:1]};
        end
        if (i_cmd.capture) begin
            case (i_cmd.op)
                OP_NAB:  r_nab <= r_acc[2*NORM_W-1:0];
                OP_DSQ:  r_dsq <= r_acc[2*MPLR_W-1:0];
                OP_TT:   r_tt  <= r_acc[TT_W-1:0];
                default: r_tt  <= r_tt;
            endcase
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= Q_ONE;
        end else if (i_cmd.srch_update) begin
            if (reaches) begin
                r_lo <= mid;
            end else begin
                r_hi <= mid - 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_res.degenerate <= degen;
            if (degen) begin
                r_res.cosine <= '0;
            end else if (r_dot[DOT_W-1]) begin
                r_res.cosine <= -$signed({1'b0, r_lo});
            end else begin
                r_res.cosine <= $signed({1'b0, r_lo});
            end
        end
    end

    assign o_sts.degen    = degen;
    assign o_sts.mul_done = (r_mplr == '0);
    assign o_sts.lo_lt_hi = (r_lo < r_hi);
    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

FILE: design/csim_ctrl.sv
// Sequencer that drives the multiply and search steps after the final pair.
`timescale 1ns / 1ps
module csim_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_last_acc,
    input  csim_pkg::t_sts i_sts,
    output csim_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import csim_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_LOAD,
        S_MUL,
        S_SRCH
    } t_state;

    t_state  r_state, n_state;
    t_mul_op r_op, n_op;
    t_cmd    cmd;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        cmd     = '0;
        cmd.op  = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_last_acc) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.degen) begin
                    cmd.emit  = 1'b1;
                    cmd.clear = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    cmd.srch_init = 1'b1;
                    n_op    = OP_NAB;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.mul_load = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                if (i_sts.mul_done) begin
                    cmd.capture = 1'b1;
                    case (r_op)
                        OP_NAB: begin
                            n_op    = OP_DSQ;
                            n_state = S_LOAD;
                        end
                        OP_DSQ: n_state = S_SRCH;
                        OP_TT: begin
                            n_op    = OP_LHS;
                            n_state = S_LOAD;
                        end
                        default: begin
                            cmd.srch_update = 1'b1;
                            n_state         = S_SRCH;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (i_sts.lo_lt_hi) begin
                    n_op    = OP_TT;
                    n_state = S_LOAD;
                end else begin
                    cmd.emit  = 1'b1;
                    cmd.clear = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NAB;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: design/cosine_similarity_engine_unit.sv
// Top level of the cosine similarity engine.
`timescale 1ns / 1ps
// Element pairs are accepted one per cycle whenever busy is low; each accepted
// request updates the dot product and both squared norms in the same cycle,
// saturating at their widths. A request with last_pair set raises busy from
// the next cycle while the result is formed: a zero norm finishes straight
// from the evaluation state, otherwise one shared bit-serial shift-add
// multiplier forms the norm product and the squared dot product (one
// multiplier bit per cycle) and then runs a binary search of up to 15 probes
// for the rounded magnitude, each probe two multiplications. The result
// shows on o_res with o_done high for exactly one cycle; the receiver cannot
// stall it, and the accumulators clear.
module cosine_similarity_engine_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  csim_pkg::t_req i_req,
    output csim_pkg::t_res o_res,
    output logic           o_done
);
    import csim_pkg::*;

    logic acc_en;
    t_cmd cmd;
    t_sts sts;

    assign acc_en = start && !busy;

    csim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_last_acc (acc_en && i_req.last_pair),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    csim_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc_en (acc_en),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_res    (o_res),
        .o_done   (o_done)
    );

endmodule

FILE: verif/cosine_similarity_checker.sv
// Checker that predicts and compares cosine similarity results.
`timescale 1ns / 1ps
module cosine_similarity_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  csim_pkg::t_req i_req,
    input  csim_pkg::t_res o_res,
    input  logic           o_done,
    output int             o_fails,
    output int             o_pending
);
    import csim_pkg::*;

    localparam longint DOT_MAX  = (64'sd1 <<< (DOT_W - 1)) - 1;
    localparam longint DOT_MIN  = -(64'sd1 <<< (DOT_W - 1));
    localparam longint NORM_MAX = (64'sd1 <<< NORM_W) - 1;

    longint dot_acc;
    longint norm_a_acc;
    longint norm_b_acc;
    t_res   cosine_queue[$];

    assign o_pending = cosine_queue.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_fails++;
    endtask

    // Largest q with (2q-1)^2 * na * nb <= 2^30 * dot^2, the rounded magnitude.
    function automatic t_res cosine_of(input longint d, input longint na, input longint nb);
        t_res        r;
        logic [127:0] nab;
        logic [127:0] rhs;
        logic [127:0] mag;
        logic [127:0] t;
        longint      lo;
        longint      hi;
        longint      mid;
        r = '0;
        if (na == 0 || nb == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        mag = (d < 0) ? 128'(-d) : 128'(d);
        nab = 128'(na) * 128'(nb);
        rhs = (mag * mag) << RHS_SH;
        lo = 0;
        hi = Q_ONE;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 128'(2 * mid - 1);
            if (nab * t * t <= rhs) lo = mid;
            else hi = mid - 1;
        end
        r.cosine = (d < 0) ? 16'(-lo) : 16'(lo);
        return r;
    endfunction

    always @(posedge i_clk) begin
        longint a;
        longint b;
        longint p;
        t_res   want;
        if (!i_rst_n) begin
            dot_acc = 0;
            norm_a_acc = 0;
            norm_b_acc = 0;
            o_fails = 0;
            cosine_queue.delete();
        end else begin
            if (o_done) begin
                if (cosine_queue.size() == 0) begin
                    report("unexpected result, cosine", o_res.cosine, 0);
                end else begin
                    want = cosine_queue.pop_front();
                    if (o_res.cosine !== want.cosine)
                        report("cosine", o_res.cosine, want.cosine);
                    if (o_res.degenerate !== want.degenerate)
                        report("degenerate", o_res.degenerate, want.degenerate);
                end
            end
            if (start && !busy) begin
                a = i_req.a_elem;
                b = i_req.b_elem;
                p = a * b;
                if (p > 0 && dot_acc > DOT_MAX - p) dot_acc = DOT_MAX;
                else if (p < 0 && dot_acc < DOT_MIN - p) dot_acc = DOT_MIN;
                else dot_acc += p;
                norm_a_acc = (norm_a_acc > NORM_MAX - a * a) ? NORM_MAX : norm_a_acc + a * a;
                norm_b_acc = (norm_b_acc > NORM_MAX - b * b) ? NORM_MAX : norm_b_acc + b * b;
                if (i_req.last_pair) begin
                    cosine_queue.push_back(cosine_of(dot_acc, norm_a_acc, norm_b_acc));
                    dot_acc = 0;
                    norm_a_acc = 0;
                    norm_b_acc = 0;
                end
            end
        end
    end
endmodule

FILE: verif/cosine_similarity_engine_unit_test.sv
// Top of the cosine similarity engine testbench: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps
module cosine_similarity_engine_unit_test;
    import csim_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    t_res o_res;
    logic o_done;
    int   fails;
    int   pending;
    int   idle_pct;
    int   sent;

    cosine_similarity_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_res(o_res), .o_done(o_done)
    );

    cosine_similarity_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_res(o_res), .o_done(o_done),
        .o_fails(fails), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10000000;
        $display("simulation failed");
        $finish;
    end

    // Holds a request until the block takes it, then maybe idles.
    task automatic send(input logic [15:0] a, input logic [15:0] b, input logic last);
        start <= 1'b1;
        i_req <= '{a_elem: a, b_elem: b, last_pair: last};
        do @(posedge i_clk); while (busy);
        sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_elem();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len);
        logic zero_a;
        logic zero_b;
        zero_a = ($urandom_range(19) == 0);
        zero_b = ($urandom_range(19) == 0);
        for (int k = 0; k < len; k++)
            send(zero_a ? 16'h0 : pick_elem(), zero_b ? 16'h0 : pick_elem(), k == len - 1);
    endtask

    initial begin
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        idle_pct = 0;
        sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single- and two-pair vectors at the extremes, and zero norms.
        send(16'h8000, 16'h8000, 1'b1);
        send(16'h8000, 16'h7fff, 1'b1);
        send(16'h7fff, 16'h7fff, 1'b1);
        send(16'h0001, 16'hffff, 1'b1);
        send(16'h0000, 16'h1234, 1'b1);
        send(16'h4321, 16'h0000, 1'b1);
        send(16'h0000, 16'h0000, 1'b1);
        send(16'h7fff, 16'h0001, 1'b0);
        send(16'h0001, 16'h7fff, 1'b1);
        send(16'h8000, 16'h7fff, 1'b0);
        send(16'h7fff, 16'h8000, 1'b1);
        // Long full-scale vectors build large sums of both signs.
        for (int k = 0; k < 150; k++) send(16'h8000, 16'h8000, k == 149);
        for (int k = 0; k < 150; k++) send(16'h8000, 16'h7fff, k == 149);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        idle_pct = 35;
        while (sent < 500) send_vector($urandom_range(0, 7) == 0 ? $urandom_range(1, 40)
                                                                 : $urandom_range(1, 8));
        // Let every outstanding result drain before resuming.
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        idle_pct = 74;
        while (sent < 680) send_vector($urandom_range(1, 10));
        idle_pct = 0;
        while (sent < 850) begin
            if ($urandom_range(9) == 0) send(pick_elem(), pick_elem(), 1'b0);
            else send_vector($urandom_range(1, 10));
        end
        start <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
design/csim_pkg.sv
design/csim_datapath.sv
design/csim_ctrl.sv
design/cosine_similarity_engine_unit.sv
verif/cosine_similarity_checker.sv
verif/cosine_similarity_engine_unit_test.sv
